>>> sv/vgpd_pkg.sv
// shared types, constants and helpers for the vector glyph primitive decoder
`timescale 1ns / 1ps

package vgpd_pkg;

  localparam int GlyphByteBits = 8;
  localparam int XScaleBits    = 11;
  localparam int YBits         = 6;
  localparam int WidthBits     = 8;

  localparam int ScaleFracBitsDefault = 12;
  localparam int XOutBitsDefault      = 9;
  localparam int JobQueueDepth        = 4;

  localparam logic [XScaleBits-1:0] XScaleReset = XScaleBits'(1024);

  localparam logic [GlyphByteBits-1:0] TypeEnd  = GlyphByteBits'(0);
  localparam logic [GlyphByteBits-1:0] TypeBox  = GlyphByteBits'(2);
  localparam logic [GlyphByteBits-1:0] TypeTri  = GlyphByteBits'(3);
  localparam logic [GlyphByteBits-1:0] TypeQuad = GlyphByteBits'(4);

  typedef enum logic [1:0] {
    PrimBox = 2'd0,
    PrimTri = 2'd1,
    PrimEnd = 2'd2
  } prim_kind_e;

  typedef enum logic [1:0] {
    JobBox  = 2'd0,
    JobTri  = 2'd1,
    JobQuad = 2'd2,
    JobEnd  = 2'd3
  } job_kind_e;

  typedef enum logic {
    BackFirst  = 1'b0,
    BackSecond = 1'b1
  } back_state_e;

  // width of one queued job: kind, glyph width, four nodes
  function automatic int job_bits(input int x_out_bits);
    return 2 + WidthBits + 4 * (x_out_bits + YBits);
  endfunction

endpackage

>>> sv/vgpd_front.sv
// front end: parses glyph bytes, scales nodes, issues primitive jobs
`timescale 1ns / 1ps

module vgpd_front import vgpd_pkg::*; #(
  parameter int SCALE_FRAC_BITS = ScaleFracBitsDefault,
  parameter int X_OUT_BITS      = XOutBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [GlyphByteBits-1:0]         glyph_byte_i,
  input  logic [GlyphByteBits-1:0]         x_base_i,
  input  logic [XScaleBits-1:0]            x_scale_i,
  output logic                             job_push_o,
  output logic [job_bits(X_OUT_BITS)-1:0]  job_o,
  input  logic                             job_full_i
);

  localparam int ProdW = GlyphByteBits + XScaleBits;
  localparam logic [ProdW:0] XLim = (ProdW+1)'((1 << X_OUT_BITS) - 1);

  typedef struct packed {
    job_kind_e                         kind;
    logic [WidthBits-1:0]              width;
    logic [3:0][X_OUT_BITS-1:0]        xs;
    logic [3:0][YBits-1:0]             ys;
  } job_t;

  logic                          phase_q, phase_d;
  logic [2:0]                    total_q, total_d;
  logic [2:0]                    idx_q, idx_d;
  logic [WidthBits-1:0]          max_q, max_d;
  logic [3:0][X_OUT_BITS-1:0]    xs_q, xs_d;
  logic [3:0][YBits-1:0]         ys_q, ys_d;

  logic                          accept;
  logic [ProdW-1:0]              prod;
  logic [ProdW-1:0]              scaled;
  logic [ProdW:0]                sum;
  logic [X_OUT_BITS-1:0]         x_new;
  logic [3:0]                    idx_next;
  job_t                          job;

  assign in_ready_o = !job_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign prod   = ProdW'(glyph_byte_i) * ProdW'(x_scale_i);
  assign scaled = prod >> SCALE_FRAC_BITS;
  assign sum    = (ProdW+1)'(x_base_i) + (ProdW+1)'(scaled);
  assign x_new  = (sum > XLim) ? XLim[X_OUT_BITS-1:0] : sum[X_OUT_BITS-1:0];

  assign idx_next = {1'b0, idx_q} + 4'd1;

  always_comb begin
    phase_d    = phase_q;
    total_d    = total_q;
    idx_d      = idx_q;
    max_d      = max_q;
    xs_d       = xs_q;
    ys_d       = ys_q;
    job_push_o = 1'b0;
    job.kind   = JobEnd;
    job.width  = max_q;
    job.xs     = xs_q;
    job.ys     = ys_q;
    if (accept) begin
      if (!phase_q) begin
        if (glyph_byte_i == TypeEnd) begin
          job_push_o = 1'b1;
          max_d      = '0;
        end else if (glyph_byte_i == TypeBox || glyph_byte_i == TypeTri ||
                     glyph_byte_i == TypeQuad) begin
          phase_d = 1'b1;
          total_d = glyph_byte_i[2:0];
          idx_d   = '0;
        end
      end else begin
        if (!idx_q[0]) begin
          if (glyph_byte_i > max_q) begin
            max_d = glyph_byte_i;
          end
          xs_d[idx_q[2:1]] = x_new;
        end else begin
          ys_d[idx_q[2:1]] = glyph_byte_i[GlyphByteBits-1:2];
        end
        if (idx_next < {total_q, 1'b0}) begin
          idx_d = idx_next[2:0];
        end else begin
          phase_d    = 1'b0;
          idx_d      = '0;
          job_push_o = 1'b1;
          job.ys     = ys_d;
          job.width  = '0;
          unique case (total_q)
            3'd2:    job.kind = JobBox;
            3'd3:    job.kind = JobTri;
            default: job.kind = JobQuad;
          endcase
        end
      end
    end
  end

  assign job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      total_q <= '0;
      idx_q   <= '0;
      max_q   <= '0;
    end else begin
      phase_q <= phase_d;
      total_q <= total_d;
      idx_q   <= idx_d;
      max_q   <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xs_q <= xs_d;
    ys_q <= ys_d;
  end

endmodule

>>> sv/vgpd_queue.sv
// small job queue between front and back
`timescale 1ns / 1ps

module vgpd_queue import vgpd_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = JobQueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             valid_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  logic [Width-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign rdata_o = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> sv/vgpd_back.sv
// back end: expands jobs into result primitives behind an output register
`timescale 1ns / 1ps

module vgpd_back import vgpd_pkg::*; #(
  parameter int X_OUT_BITS = XOutBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             job_valid_i,
  input  logic [job_bits(X_OUT_BITS)-1:0]  job_i,
  output logic                             job_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       prim_kind_o,
  output logic [X_OUT_BITS-1:0]            p0_x_o,
  output logic [YBits-1:0]                 p0_y_o,
  output logic [X_OUT_BITS-1:0]            p1_x_o,
  output logic [YBits-1:0]                 p1_y_o,
  output logic [X_OUT_BITS-1:0]            p2_x_o,
  output logic [YBits-1:0]                 p2_y_o,
  output logic [WidthBits-1:0]             glyph_width_o,
  output logic                             last_of_run_o
);

  typedef struct packed {
    job_kind_e                         kind;
    logic [WidthBits-1:0]              width;
    logic [3:0][X_OUT_BITS-1:0]        xs;
    logic [3:0][YBits-1:0]             ys;
  } job_t;

  typedef struct packed {
    prim_kind_e                kind;
    logic [X_OUT_BITS-1:0]     p0_x;
    logic [YBits-1:0]          p0_y;
    logic [X_OUT_BITS-1:0]     p1_x;
    logic [YBits-1:0]          p1_y;
    logic [X_OUT_BITS-1:0]     p2_x;
    logic [YBits-1:0]          p2_y;
    logic [WidthBits-1:0]      width;
    logic                      last;
  } result_t;

  job_t        job;
  result_t     res, res_q;
  back_state_e state_q, state_d;
  logic        valid_q;
  logic        load, take, quad_first;

  assign job        = job_i;
  assign load       = !valid_q || out_ready_i;
  assign take       = load && job_valid_i;
  assign quad_first = (job.kind == JobQuad) && (state_q == BackFirst);

  // next state
  always_comb begin
    state_d = state_q;
    if (take) begin
      state_d = quad_first ? BackSecond : BackFirst;
    end
  end

  // outputs
  always_comb begin
    job_pop_o = take && !quad_first;
    res       = '0;
    res.last  = 1'b1;
    unique case (job.kind)
      JobBox: begin
        res.kind = PrimBox;
        if (job.xs[0] < job.xs[1]) begin
          res.p0_x = job.xs[0];
          res.p1_x = job.xs[1] - job.xs[0];
        end else begin
          res.p0_x = job.xs[1];
          res.p1_x = job.xs[0] - job.xs[1];
        end
        if (job.ys[0] < job.ys[1]) begin
          res.p0_y = job.ys[0];
          res.p1_y = job.ys[1] - job.ys[0];
        end else begin
          res.p0_y = job.ys[1];
          res.p1_y = job.ys[0] - job.ys[1];
        end
      end
      JobTri: begin
        res.kind = PrimTri;
        res.p0_x = job.xs[0];
        res.p0_y = job.ys[0];
        res.p1_x = job.xs[1];
        res.p1_y = job.ys[1];
        res.p2_x = job.xs[2];
        res.p2_y = job.ys[2];
      end
      JobQuad: begin
        res.kind = PrimTri;
        res.p1_x = job.xs[1];
        res.p1_y = job.ys[1];
        if (state_q == BackFirst) begin
          // triangle 0,1,3
          res.p0_x = job.xs[0];
          res.p0_y = job.ys[0];
          res.p2_x = job.xs[3];
          res.p2_y = job.ys[3];
          res.last = 1'b0;
        end else begin
          // triangle 3,1,2
          res.p0_x = job.xs[3];
          res.p0_y = job.ys[3];
          res.p2_x = job.xs[2];
          res.p2_y = job.ys[2];
        end
      end
      JobEnd: begin
        res.kind  = PrimEnd;
        res.width = job.width;
      end
      default: res.kind = PrimEnd;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BackFirst;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        valid_q <= job_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = valid_q;
  assign prim_kind_o   = res_q.kind;
  assign p0_x_o        = res_q.p0_x;
  assign p0_y_o        = res_q.p0_y;
  assign p1_x_o        = res_q.p1_x;
  assign p1_y_o        = res_q.p1_y;
  assign p2_x_o        = res_q.p2_x;
  assign p2_y_o        = res_q.p2_y;
  assign glyph_width_o = res_q.width;
  assign last_of_run_o = res_q.last;

endmodule

>>> sv/vector_glyph_primitive_decoder.sv
// top level of the vector glyph primitive decoder
//
// input channel: in_valid_i/in_ready_o move one glyph record byte per transfer,
//   together with the glyph's base x; a type byte opens a box, triangle or
//   quadrangle, node x,y bytes follow, a zero byte ends the glyph
// output channel: out_valid_o/out_ready_i move one primitive per transfer
//   (box, triangle or glyph end); last_of_run_o marks the final result of
//   the byte that caused it
// config: cfg_we_i writes the 11 bit horizontal scale (Q0.12), taken at once
// throughput: one byte per cycle while the queue has room; the back end
//   emits one result per cycle while ready: a quadrangle's nine bytes give two
// a polygon's last byte (or the end byte) pushes its job into the job queue;
//   its first result is then registered from there into the output register
// the node multiply, add and saturate are combinational in the front end;
//   a four-entry job queue separates front from back
// when the receiver stalls the output register holds, the back end stops, and
//   the front keeps taking bytes until the job queue fills
// reset clears parser state, the running maximum x, the queue and the output
//   valid, and sets the scale to 0.25; no clearing pass is needed
`timescale 1ns / 1ps

module vector_glyph_primitive_decoder import vgpd_pkg::*; #(
  parameter int SCALE_FRAC_BITS = ScaleFracBitsDefault,
  parameter int X_OUT_BITS      = XOutBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [GlyphByteBits-1:0] glyph_byte_i,
  input  logic [GlyphByteBits-1:0] x_base_i,
  input  logic                     cfg_we_i,
  input  logic [XScaleBits-1:0]    cfg_wdata_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               prim_kind_o,
  output logic [X_OUT_BITS-1:0]    p0_x_o,
  output logic [YBits-1:0]         p0_y_o,
  output logic [X_OUT_BITS-1:0]    p1_x_o,
  output logic [YBits-1:0]         p1_y_o,
  output logic [X_OUT_BITS-1:0]    p2_x_o,
  output logic [YBits-1:0]         p2_y_o,
  output logic [WidthBits-1:0]     glyph_width_o,
  output logic                     last_of_run_o
);

  localparam int JobBits = job_bits(X_OUT_BITS);

  logic [XScaleBits-1:0] x_scale_q12_q;
  logic                  job_push, job_full, job_valid, job_pop;
  logic [JobBits-1:0]    job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_scale_q12_q <= XScaleReset;
    end else if (cfg_we_i) begin
      x_scale_q12_q <= cfg_wdata_i;
    end
  end

  vgpd_front #(
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS),
    .X_OUT_BITS     (X_OUT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .glyph_byte_i(glyph_byte_i),
    .x_base_i    (x_base_i),
    .x_scale_i   (x_scale_q12_q),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .job_full_i  (job_full)
  );

  vgpd_queue #(
    .Width(JobBits),
    .Depth(JobQueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .wdata_i(job_in),
    .full_o (job_full),
    .pop_i  (job_pop),
    .rdata_o(job_out),
    .valid_o(job_valid)
  );

  vgpd_back #(
    .X_OUT_BITS(X_OUT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_i        (job_out),
    .job_pop_o    (job_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .prim_kind_o  (prim_kind_o),
    .p0_x_o       (p0_x_o),
    .p0_y_o       (p0_y_o),
    .p1_x_o       (p1_x_o),
    .p1_y_o       (p1_y_o),
    .p2_x_o       (p2_x_o),
    .p2_y_o       (p2_y_o),
    .glyph_width_o(glyph_width_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

>>> sv/vgpd_checker.sv
// port-level checker for the vector glyph primitive decoder and its bind
`timescale 1ns / 1ps

module vgpd_checker import vgpd_pkg::*; #(
  parameter int X_OUT_BITS = XOutBitsDefault
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [1:0]               prim_kind_i,
  input logic [X_OUT_BITS-1:0]    p0_x_i,
  input logic [YBits-1:0]         p0_y_i,
  input logic [X_OUT_BITS-1:0]    p2_x_i,
  input logic [YBits-1:0]         p2_y_i,
  input logic [WidthBits-1:0]     glyph_width_i,
  input logic                     last_of_run_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(prim_kind_i) &&
      $stable(p0_x_i) && $stable(last_of_run_i))
    else $error("stalled result changed");

  // glyph end carries no points and closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && prim_kind_i == PrimEnd |->
      last_of_run_i && p0_x_i == '0 && p0_y_i == '0 && p2_x_i == '0 && p2_y_i == '0)
    else $error("bad glyph end result");

  // only glyph end reports a width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && prim_kind_i != PrimEnd |-> glyph_width_i == '0)
    else $error("width on non-end result");

  // box has no third point and is always final
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && prim_kind_i == PrimBox |-> last_of_run_i && p2_x_i == '0 && p2_y_i == '0)
    else $error("bad box result");

  // a non-final triangle is followed by the final one of the pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_of_run_i |=>
      out_valid_i && prim_kind_i == PrimTri && last_of_run_i)
    else $error("quad pair broken");

endmodule

bind vector_glyph_primitive_decoder vgpd_checker #(
  .X_OUT_BITS(X_OUT_BITS)
) u_vgpd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .prim_kind_i  (prim_kind_o),
  .p0_x_i       (p0_x_o),
  .p0_y_i       (p0_y_o),
  .p2_x_i       (p2_x_o),
  .p2_y_i       (p2_y_o),
  .glyph_width_i(glyph_width_o),
  .last_of_run_i(last_of_run_o)
);
